// File: rtl/rsc_pkg.sv
// shared types, constants and fixed-point helpers for the string resonator comb
`default_nettype none
package rsc_pkg;

  localparam int SampleW = 24;
  localparam int CoefW   = 18;
  localparam int ProdW   = SampleW + CoefW;
  localparam int RndW    = ProdW - 15;
  localparam int SumW    = RndW + 1;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 18;

  localparam logic [CfgIdxW-1:0] REG_DELAY_SAMPLES = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ALLPASS_COEF  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FEEDBACK_GAIN = 2'd2;

  localparam logic [16:0]       Q16_ONE_U = 17'd65536;
  localparam logic signed [17:0] Q16_ONE_S = 18'sd65536;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [RndW-1:0]    rnd_t;
  typedef logic signed [SumW-1:0]    sum_t;

  // control of the shared multiplier
  typedef struct packed {
    logic                      en;
    logic signed [SampleW-1:0] op_a;
    logic signed [CoefW-1:0]   op_b;
  } mul_req_t;

  // clamp to the signed 24-bit range
  function automatic sample_t sat24(input sum_t v);
    sample_t r;
    if (v > sum_t'(24'sh7FFFFF)) begin
      r = 24'sh7FFFFF;
    end else if (v < sum_t'(24'sh800000)) begin
      r = 24'sh800000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

  // q1.16 product rounded half up
  function automatic rnd_t rnd_q16(input prod_t p);
    logic signed [ProdW:0] t;
    t = (ProdW+1)'(p) + (ProdW+1)'(32768);
    return t[ProdW:16];
  endfunction

endpackage
`default_nettype wire

// File: rtl/rsc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module rsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/rsc_mul.sv
// shared signed 24x18 multiplier with registered product
`default_nettype none
module rsc_mul (
  input  wire logic             clk_i,
  input  wire rsc_pkg::mul_req_t req_i,
  output      rsc_pkg::prod_t   prod_o
);

  rsc_pkg::prod_t prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= rsc_pkg::ProdW'(req_i.op_a) * rsc_pkg::ProdW'(req_i.op_b);
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// File: rtl/string_resonator_comb_unit.sv
// top level of the string resonator comb: sequencer, state and delay line
// a result passes READ, MUL_SA, SUM_Y, MUL_YA, AP and WRITE into the output register
// one sample at a time: input is not ready until the sequencer that runs three
//   products through one shared multiplier plus one delay line read and write is idle
// a new sample is taken while the previous result still waits in the output register
// reset: async active low; control and config registers reset, the delay line reads as
//   zero through a fill flag, so no clearing pass is needed and input is taken at once
`default_nettype none
module string_resonator_comb_unit #(
  parameter int LINE_DEPTH = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input sample stream
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  input  wire logic [23:0]                    s_axis_tdata_i,  // [23:0] sample_in
  // output sample stream
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output      logic [23:0]                    m_axis_tdata_o,  // [23:0] sample_out
  // register write channel
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [rsc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rsc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int AW      = $clog2(LINE_DEPTH);
  localparam int DW      = AW + 1;
  localparam int CW      = (DW > 12) ? DW : 12;
  localparam int DLY_RST = (100 > LINE_DEPTH) ? LINE_DEPTH : 100;

  // sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_MUL_SA = 3'd2;
  localparam logic [2:0] ST_SUM_Y  = 3'd3;
  localparam logic [2:0] ST_MUL_YA = 3'd4;
  localparam logic [2:0] ST_AP     = 3'd5;
  localparam logic [2:0] ST_WRITE  = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration, stored already clamped to the effective range
  logic [DW-1:0]        delay_q;
  logic [16:0]          coef_q;
  logic signed [17:0]   gain_q;
  logic [CW-1:0]        dly_raw;
  logic [DW-1:0]        dly_eff;
  logic [16:0]          coef_eff;
  logic signed [17:0]   gain_raw;
  logic signed [17:0]   gain_eff;

  // per-sample working registers
  rsc_pkg::sample_t     x_q, s_q, y_q;
  rsc_pkg::sample_t     lp_q, ap_q;
  rsc_pkg::sample_t     out_q;
  logic                 out_valid_q;
  logic                 rd_valid_q;

  // write pointer and fill tracking: entries at or above wp_q are unwritten until wrap
  logic [AW-1:0]        wp_q;
  logic                 full_q;
  logic [DW-1:0]        wp_ext;
  logic [AW-1:0]        rp;

  // datapath
  logic [23:0]          ram_rdata;
  rsc_pkg::sample_t     line_rd;
  logic signed [24:0]   xr_sum;
  rsc_pkg::sample_t     w_val;
  logic signed [24:0]   lp_sum;
  rsc_pkg::prod_t       prod;
  rsc_pkg::rnd_t        prod_rnd;
  rsc_pkg::sample_t     wr_val;
  rsc_pkg::mul_req_t    mul_req;

  logic in_fire;
  logic out_free;
  logic wr_fire;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign wr_fire         = (state_q == ST_WRITE) & out_free;
  assign cfg_ready_o     = 1'b1;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // ---------------- configuration ----------------
  // delay of zero acts as one, anything beyond the line acts as the full line
  always_comb begin
    dly_raw = CW'(cfg_data_i[11:0]);
    if (dly_raw == '0) begin
      dly_eff = DW'(1);
    end else if (dly_raw > CW'(LINE_DEPTH)) begin
      dly_eff = DW'(LINE_DEPTH);
    end else begin
      dly_eff = dly_raw[DW-1:0];
    end
  end

  assign coef_eff = (cfg_data_i[16:0] > rsc_pkg::Q16_ONE_U) ? rsc_pkg::Q16_ONE_U
                                                           : cfg_data_i[16:0];

  always_comb begin
    gain_raw = $signed(cfg_data_i[17:0]);
    if (gain_raw > rsc_pkg::Q16_ONE_S) begin
      gain_eff = rsc_pkg::Q16_ONE_S;
    end else if (gain_raw < -rsc_pkg::Q16_ONE_S) begin
      gain_eff = -rsc_pkg::Q16_ONE_S;
    end else begin
      gain_eff = gain_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DW'(DLY_RST);
      coef_q  <= rsc_pkg::Q16_ONE_U;
      gain_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rsc_pkg::REG_DELAY_SAMPLES: delay_q <= dly_eff;
        rsc_pkg::REG_ALLPASS_COEF:  coef_q  <= coef_eff;
        rsc_pkg::REG_FEEDBACK_GAIN: gain_q  <= gain_eff;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------- delay line ----------------
  // read pointer trails the write pointer by the delay, modulo the line length
  always_comb begin
    wp_ext = {1'b0, wp_q};
    if (wp_ext >= delay_q) begin
      rp = AW'(wp_ext - delay_q);
    end else begin
      rp = AW'(wp_ext + DW'(LINE_DEPTH) - delay_q);
    end
  end

  rsc_ram #(
    .WIDTH (24),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr_fire),
    .waddr_i (wp_q),
    .wdata_i (wr_val),
    .re_i    (in_fire),
    .raddr_i (rp),
    .rdata_o (ram_rdata)
  );

  // unwritten entries read as zero
  assign line_rd = rd_valid_q ? $signed(ram_rdata) : '0;

  // ---------------- shared multiplier ----------------
  always_comb begin
    mul_req.en   = 1'b0;
    mul_req.op_a = y_q;
    mul_req.op_b = $signed({1'b0, coef_q});
    unique case (state_q)
      ST_MUL_SA: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = s_q;
      end
      ST_MUL_YA: begin
        mul_req.en   = 1'b1;
      end
      ST_AP: begin
        mul_req.en   = 1'b1;
        mul_req.op_b = gain_q;
      end
      default: ;
    endcase
  end

  rsc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign prod_rnd = rsc_pkg::rnd_q16(prod);

  // comb sum and two-tap average
  assign xr_sum = 25'(x_q) + 25'(line_rd);
  assign w_val  = rsc_pkg::sat24(rsc_pkg::SumW'(xr_sum));
  assign lp_sum = 25'(lp_q) + 25'(w_val);
  // feedback sample written back into the line
  assign wr_val = rsc_pkg::sat24(rsc_pkg::SumW'(prod_rnd));

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) begin
        state_d = ST_READ;
      end
      ST_READ:   state_d = ST_MUL_SA;
      ST_MUL_SA: state_d = ST_SUM_Y;
      ST_SUM_Y:  state_d = ST_MUL_YA;
      ST_MUL_YA: state_d = ST_AP;
      ST_AP:     state_d = ST_WRITE;
      ST_WRITE:  if (out_free) begin
        state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      full_q      <= 1'b0;
      lp_q        <= '0;
      ap_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_READ) begin
        lp_q <= w_val;
      end
      if (state_q == ST_AP) begin
        ap_q <= rsc_pkg::sat24(rsc_pkg::SumW'(s_q) - rsc_pkg::SumW'(prod_rnd));
      end
      if (wr_fire) begin
        if (wp_q == AW'(LINE_DEPTH - 1)) begin
          wp_q   <= '0;
          full_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AW'(1);
        end
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q        <= $signed(s_axis_tdata_i);
      rd_valid_q <= full_q | (rp < wp_q);
    end
    if (state_q == ST_READ) begin
      s_q <= lp_sum[24:1];
    end
    if (state_q == ST_SUM_Y) begin
      y_q <= rsc_pkg::sat24(rsc_pkg::SumW'(ap_q) + rsc_pkg::SumW'(prod_rnd));
    end
    if (wr_fire) begin
      out_q <= y_q;
    end
  end

endmodule
`default_nettype wire

// File: rtl/rsc_checker.sv
// port-level checks for the string resonator comb, bound to the top level
`default_nettype none
module rsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o,
  input wire logic        cfg_ready_o
);

  logic in_fire;

  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transaction changed while stalled");

  // the sequencer stays busy after a transaction, with input not ready while it steps from READ to WRITE
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o ##1 !s_axis_tready_o ##1 !s_axis_tready_o
                ##1 !s_axis_tready_o ##1 !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("input taken while a sample is in work");

  // a new result only appears at the end of a sample's work
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without a sample in work");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("register port not ready");

endmodule

bind string_resonator_comb_unit rsc_checker u_rsc_checker (.*);
`default_nettype wire
